FILE: hdl/ddo_pkg.sv
package ddo_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int ANG_TAB_LEN = 24;
    localparam int ITER_W = $clog2(ANG_TAB_LEN);

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [63:0] RAD_TO_BAM = 64'sd683565276;
    localparam logic signed [63:0] USEC_PER_SEC = 64'sd1000000;
    localparam logic [30:0] TW_RESET = 31'd65536;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [3:0] op_t;

    localparam op_t OP_THETA   = 4'd0;
    localparam op_t OP_P       = 4'd1;
    localparam op_t OP_COR_H   = 4'd2;
    localparam op_t OP_CH_MUL  = 4'd3;
    localparam op_t OP_CH_DIV  = 4'd4;
    localparam op_t OP_COR_DIR = 4'd5;
    localparam op_t OP_DX      = 4'd6;
    localparam op_t OP_DY      = 4'd7;
    localparam op_t OP_SP_MUL  = 4'd8;
    localparam op_t OP_SP_DIV  = 4'd9;
    localparam op_t OP_RT_MUL  = 4'd10;
    localparam op_t OP_RT_DIV  = 4'd11;

    typedef struct packed {
        logic load_in;
        logic start;
        logic capture;
        logic load_out;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic theta_zero;
        logic dt_zero;
    } status_t;

    function automatic logic op_is_div(input op_t op);
        return (op == OP_THETA) || (op == OP_CH_DIV) || (op == OP_SP_DIV) ||
               (op == OP_RT_DIV);
    endfunction

    function automatic logic op_is_cor(input op_t op);
        return (op == OP_COR_H) || (op == OP_COR_DIR);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // arctan(2^-i) as binary angle, 2^32 per turn
    function automatic logic signed [33:0] ang_tab(input logic [ITER_W-1:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:    r = 34'sd536870912;
            5'd1:    r = 34'sd316933406;
            5'd2:    r = 34'sd167458907;
            5'd3:    r = 34'sd85004756;
            5'd4:    r = 34'sd42667331;
            5'd5:    r = 34'sd21354465;
            5'd6:    r = 34'sd10680862;
            5'd7:    r = 34'sd5340245;
            5'd8:    r = 34'sd2670163;
            5'd9:    r = 34'sd1335087;
            5'd10:   r = 34'sd667544;
            5'd11:   r = 34'sd333772;
            5'd12:   r = 34'sd166886;
            5'd13:   r = 34'sd83443;
            5'd14:   r = 34'sd41722;
            5'd15:   r = 34'sd20861;
            5'd16:   r = 34'sd10430;
            5'd17:   r = 34'sd5215;
            5'd18:   r = 34'sd2608;
            5'd19:   r = 34'sd1304;
            5'd20:   r = 34'sd652;
            5'd21:   r = 34'sd326;
            5'd22:   r = 34'sd163;
            5'd23:   r = 34'sd81;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/ddo_muldiv.sv
module ddo_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                is_div,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  result
);

    logic                           busy_reg;
    logic                           done_reg;
    logic                           div_reg;
    logic                           neg_reg;
    logic [ddo_pkg::CNT_W-1:0]      cnt_reg;
    logic [63:0]                    x_reg;
    logic [63:0]                    y_reg;
    logic [63:0]                    acc_reg;
    logic [64:0]                    rem_reg;

    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [64:0] rem_sh;
    logic [63:0] raw;

    assign mag_a = a[63] ? (~a + 64'd1) : a;
    assign mag_b = b[63] ? (~b + 64'd1) : b;
    assign rem_sh = {rem_reg[63:0], y_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == ddo_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= is_div;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 64'd0;
            rem_reg <= 65'd0;
            if (is_div)
            begin
                x_reg   <= mag_b;
                y_reg   <= mag_a;
                cnt_reg <= ddo_pkg::CNT_W'(ddo_pkg::DIV_STEPS);
            end
            else
            begin
                x_reg   <= mag_a;
                y_reg   <= mag_b;
                cnt_reg <= ddo_pkg::CNT_W'(ddo_pkg::MUL_STEPS);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - ddo_pkg::CNT_W'(1);
            if (div_reg)
            begin
                // restoring step: one quotient bit shifts in where the numerator leaves
                if (rem_sh >= {1'b0, x_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, x_reg};
                    y_reg   <= {y_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    y_reg   <= {y_reg[62:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                    acc_reg <= acc_reg + x_reg;
                x_reg <= {x_reg[62:0], 1'b0};
                y_reg <= {1'b0, y_reg[63:1]};
            end
        end
    end

    assign raw = div_reg ? y_reg : acc_reg;
    assign result = neg_reg ? -$signed(raw) : $signed(raw);
    assign done = done_reg;

endmodule

FILE: hdl/ddo_cordic.sv
module ddo_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         angle,
    output logic                done,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out
);

    logic                           busy_reg;
    logic                           done_reg;
    logic                           flip_reg;
    logic [ddo_pkg::ITER_W-1:0]     idx_reg;
    logic signed [33:0]             x_reg;
    logic signed [33:0]             y_reg;
    logic signed [33:0]             z_reg;

    logic               fold;
    logic [31:0]        folded;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] step_ang;

    // fold the right half-plane-opposite angles by pi
    assign fold = (angle >= 32'h40000000) && (angle < 32'hC0000000);
    assign folded = fold ? (angle - 32'h80000000) : angle;
    assign xs = x_reg >>> idx_reg;
    assign ys = y_reg >>> idx_reg;
    assign step_ang = ddo_pkg::ang_tab(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg &&
                     idx_reg == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_ITERS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= fold;
            idx_reg  <= '0;
            x_reg    <= ddo_pkg::CORDIC_GAIN;
            y_reg    <= 34'sd0;
            z_reg    <= {{2{folded[31]}}, folded};
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_reg + ddo_pkg::ITER_W'(1);
            if (z_reg >= 34'sd0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
        end
    end

    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign done = done_reg;

endmodule

FILE: hdl/ddo_datapath.sv
module ddo_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ddo_pkg::cmd_t           cmd,
    output ddo_pkg::status_t        status,
    input  logic                    cfg_we,
    input  logic [30:0]             cfg_data,
    input  logic signed [31:0]      right_distance,
    input  logic signed [31:0]      left_distance,
    input  logic [23:0]             elapsed_us,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [15:0]      heading,
    output logic signed [31:0]      speed,
    output logic signed [31:0]      turn_rate
);

    logic [30:0]            tw_reg;
    logic [31:0]            prev_r_reg;
    logic [31:0]            prev_l_reg;
    logic signed [31:0]     dm_reg;
    logic signed [33:0]     diff_reg;
    logic [23:0]            dt_reg;
    logic signed [31:0]     theta_reg;
    logic [31:0]            full_reg;
    logic [31:0]            half_reg;
    logic signed [33:0]     sh_reg;
    logic signed [33:0]     cd_reg;
    logic signed [33:0]     sd_reg;
    logic signed [63:0]     tmp_reg;
    logic signed [63:0]     chord_reg;
    logic [31:0]            px_reg;
    logic [31:0]            py_reg;
    logic [15:0]            hd_reg;
    logic signed [31:0]     speed_reg;
    logic signed [31:0]     rate_reg;
    logic signed [31:0]     pos_x_reg;
    logic signed [31:0]     pos_y_reg;
    logic signed [15:0]     heading_reg;
    logic signed [31:0]     speed_out_reg;
    logic signed [31:0]     rate_out_reg;

    logic signed [31:0] dr;
    logic signed [31:0] dl;
    logic signed [32:0] dsum;
    logic signed [32:0] dm_round;
    logic [30:0]        tw_eff;
    logic               md_start;
    logic               md_is_div;
    logic signed [63:0] md_a;
    logic signed [63:0] md_b;
    logic               md_done;
    logic signed [63:0] md_result;
    logic               cor_start;
    logic [31:0]        cor_angle;
    logic               cor_done;
    logic signed [33:0] cor_cos;
    logic signed [33:0] cor_sin;
    logic [63:0]        full_sum;
    logic [63:0]        half_sum;
    logic [63:0]        pos_sum;
    logic [31:0]        hd_sum;

    assign dr = right_distance - prev_r_reg;
    assign dl = left_distance - prev_l_reg;
    assign dsum = 33'(dr) + 33'(dl);
    // halve toward zero
    assign dm_round = dsum + (dsum[32] ? 33'sd1 : 33'sd0);
    assign tw_eff = (tw_reg == 31'd0) ? 31'd1 : tw_reg;

    always_comb
    begin
        md_a = 64'sd0;
        md_b = 64'sd0;
        cor_angle = 32'd0;
        case (cmd.op)
            ddo_pkg::OP_THETA:
            begin
                md_a = 64'(diff_reg) <<< 16;
                md_b = $signed({33'd0, tw_eff});
            end
            ddo_pkg::OP_P:
            begin
                md_a = 64'(theta_reg);
                md_b = ddo_pkg::RAD_TO_BAM;
            end
            ddo_pkg::OP_COR_H:
                cor_angle = half_reg;
            ddo_pkg::OP_CH_MUL:
            begin
                md_a = 64'(dm_reg);
                md_b = 64'(sh_reg);
            end
            ddo_pkg::OP_CH_DIV:
            begin
                md_a = tmp_reg;
                md_b = 64'(theta_reg) <<< 13;
            end
            ddo_pkg::OP_COR_DIR:
                cor_angle = {hd_reg, 16'd0} + half_reg;
            ddo_pkg::OP_DX:
            begin
                md_a = chord_reg;
                md_b = 64'(cd_reg);
            end
            ddo_pkg::OP_DY:
            begin
                md_a = chord_reg;
                md_b = 64'(sd_reg);
            end
            ddo_pkg::OP_SP_MUL:
            begin
                md_a = 64'(dm_reg);
                md_b = ddo_pkg::USEC_PER_SEC;
            end
            ddo_pkg::OP_RT_MUL:
            begin
                md_a = 64'(theta_reg);
                md_b = ddo_pkg::USEC_PER_SEC;
            end
            ddo_pkg::OP_SP_DIV,
            ddo_pkg::OP_RT_DIV:
            begin
                md_a = tmp_reg;
                md_b = $signed({40'd0, dt_reg});
            end
            default:
            begin
                md_a = 64'sd0;
            end
        endcase
    end

    assign md_is_div = ddo_pkg::op_is_div(cmd.op);
    assign md_start = cmd.start && !ddo_pkg::op_is_cor(cmd.op);
    assign cor_start = cmd.start && ddo_pkg::op_is_cor(cmd.op);

    ddo_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (md_is_div),
        .a      (md_a),
        .b      (md_b),
        .done   (md_done),
        .result (md_result)
    );

    ddo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign full_sum = md_result + 64'sd32768;
    assign half_sum = md_result + 64'sd65536;
    assign pos_sum = md_result + 64'sd536870912;
    assign hd_sum = {hd_reg, 16'd0} + full_reg + 32'h8000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg     <= ddo_pkg::TW_RESET;
            prev_r_reg <= 32'd0;
            prev_l_reg <= 32'd0;
            px_reg     <= 32'd0;
            py_reg     <= 32'd0;
            hd_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
                tw_reg <= cfg_data;
            if (cmd.load_in)
            begin
                prev_r_reg <= right_distance;
                prev_l_reg <= left_distance;
            end
            if (cmd.capture && cmd.op == ddo_pkg::OP_DX)
                px_reg <= px_reg + pos_sum[61:30];
            if (cmd.capture && cmd.op == ddo_pkg::OP_DY)
            begin
                py_reg <= py_reg + pos_sum[61:30];
                hd_reg <= hd_sum[31:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dm_reg   <= dm_round[32:1];
            diff_reg <= 34'(dr) - 34'(dl);
            dt_reg   <= elapsed_us;
        end
        if (cmd.capture)
        begin
            case (cmd.op)
                ddo_pkg::OP_THETA:
                begin
                    // straight-step defaults, kept for each op that is skipped
                    theta_reg <= ddo_pkg::sat32(md_result);
                    full_reg  <= 32'd0;
                    half_reg  <= 32'd0;
                    chord_reg <= 64'(dm_reg);
                    speed_reg <= 32'sd0;
                    rate_reg  <= 32'sd0;
                end
                ddo_pkg::OP_P:
                begin
                    full_reg <= full_sum[47:16];
                    half_reg <= half_sum[48:17];
                end
                ddo_pkg::OP_COR_H:
                    sh_reg <= cor_sin;
                ddo_pkg::OP_CH_MUL,
                ddo_pkg::OP_SP_MUL,
                ddo_pkg::OP_RT_MUL:
                    tmp_reg <= md_result;
                ddo_pkg::OP_CH_DIV:
                    chord_reg <= md_result;
                ddo_pkg::OP_COR_DIR:
                begin
                    cd_reg <= cor_cos;
                    sd_reg <= cor_sin;
                end
                ddo_pkg::OP_SP_DIV:
                    speed_reg <= ddo_pkg::sat32(md_result);
                ddo_pkg::OP_RT_DIV:
                    rate_reg <= ddo_pkg::sat32(md_result);
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            pos_x_reg     <= px_reg;
            pos_y_reg     <= py_reg;
            heading_reg   <= hd_reg;
            speed_out_reg <= speed_reg;
            rate_out_reg  <= rate_reg;
        end
    end

    assign status.done = md_done || cor_done;
    assign status.theta_zero = (theta_reg == 32'sd0);
    assign status.dt_zero = (dt_reg == 24'd0);

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign heading = heading_reg;
    assign speed = speed_out_reg;
    assign turn_rate = rate_out_reg;

endmodule

FILE: hdl/ddo_ctrl.sv
module ddo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ddo_pkg::status_t    status,
    output ddo_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_THETA   = 4'd1;
    localparam logic [3:0] S_P       = 4'd2;
    localparam logic [3:0] S_COR_H   = 4'd3;
    localparam logic [3:0] S_CH_MUL  = 4'd4;
    localparam logic [3:0] S_CH_DIV  = 4'd5;
    localparam logic [3:0] S_COR_DIR = 4'd6;
    localparam logic [3:0] S_DX      = 4'd7;
    localparam logic [3:0] S_DY      = 4'd8;
    localparam logic [3:0] S_SP_MUL  = 4'd9;
    localparam logic [3:0] S_SP_DIV  = 4'd10;
    localparam logic [3:0] S_RT_MUL  = 4'd11;
    localparam logic [3:0] S_RT_DIV  = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    logic [3:0]     state_reg;
    logic [3:0]     state_next;
    logic           launched_reg;
    logic           launched_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [3:0]     after_op;
    logic           skip;
    ddo_pkg::op_t   op_sel;

    always_comb
    begin
        op_sel = ddo_pkg::OP_THETA;
        after_op = S_IDLE;
        case (state_reg)
            S_THETA:   begin op_sel = ddo_pkg::OP_THETA;   after_op = S_P;       end
            S_P:       begin op_sel = ddo_pkg::OP_P;       after_op = S_COR_H;   end
            S_COR_H:   begin op_sel = ddo_pkg::OP_COR_H;   after_op = S_CH_MUL;  end
            S_CH_MUL:  begin op_sel = ddo_pkg::OP_CH_MUL;  after_op = S_CH_DIV;  end
            S_CH_DIV:  begin op_sel = ddo_pkg::OP_CH_DIV;  after_op = S_COR_DIR; end
            S_COR_DIR: begin op_sel = ddo_pkg::OP_COR_DIR; after_op = S_DX;      end
            S_DX:      begin op_sel = ddo_pkg::OP_DX;      after_op = S_DY;      end
            S_DY:      begin op_sel = ddo_pkg::OP_DY;      after_op = S_SP_MUL;  end
            S_SP_MUL:  begin op_sel = ddo_pkg::OP_SP_MUL;  after_op = S_SP_DIV;  end
            S_SP_DIV:  begin op_sel = ddo_pkg::OP_SP_DIV;  after_op = S_RT_MUL;  end
            S_RT_MUL:  begin op_sel = ddo_pkg::OP_RT_MUL;  after_op = S_RT_DIV;  end
            S_RT_DIV:  begin op_sel = ddo_pkg::OP_RT_DIV;  after_op = S_OUT;     end
            default:   begin op_sel = ddo_pkg::OP_THETA;   after_op = S_IDLE;    end
        endcase
    end

    // zero turn skips the chord work; zero elapsed time skips the velocities
    assign skip = ((state_reg == S_P) && status.theta_zero) ||
                  ((state_reg == S_SP_MUL) && status.dt_zero);

    always_comb
    begin
        state_next = state_reg;
        launched_next = launched_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op = op_sel;
        cmd.load_in = 1'b0;
        cmd.start = 1'b0;
        cmd.capture = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_THETA;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                if (!launched_reg)
                begin
                    if (skip)
                        state_next = (state_reg == S_P) ? S_COR_DIR : S_OUT;
                    else
                    begin
                        cmd.start = 1'b1;
                        launched_next = 1'b1;
                    end
                end
                else if (status.done)
                begin
                    cmd.capture = 1'b1;
                    launched_next = 1'b0;
                    state_next = after_op;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            launched_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            launched_reg <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/diff_drive_odometry_update.sv
// Channel   Handshake              Word
// in        in_valid / in_ready    right_distance, left_distance, elapsed_us
// out       out_valid / out_ready  pos_x, pos_y, heading, speed, turn_rate
// cfg       cfg_we                 cfg_data (track width)
//
// One word at a time; the time per word is set by the bit-serial multiply/divide unit and
// the 16-step CORDIC, and is shorter for a straight step or one with zero elapsed time,
// where the chord or the speed and turn-rate operations are skipped.
// rst_n clears pose, previous distances and control; track width resets to 1.0 m.
// A finished word waits in the output register; the next input word is taken meanwhile.
module diff_drive_odometry_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  right_distance,
    input  logic signed [31:0]  left_distance,
    input  logic [23:0]         elapsed_us,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [15:0]  heading,
    output logic signed [31:0]  speed,
    output logic signed [31:0]  turn_rate,
    input  logic                cfg_we,
    input  logic [30:0]         cfg_data
);

    ddo_pkg::cmd_t      cmd;
    ddo_pkg::status_t   status;

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ddo_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .right_distance (right_distance),
        .left_distance  (left_distance),
        .elapsed_us     (elapsed_us),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .heading        (heading),
        .speed          (speed),
        .turn_rate      (turn_rate)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after accepting a word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid || out_ready)
        else $error("result overwritten while still pending");

    a_capture_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> status.done)
        else $error("capture without unit done");

    a_unit_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !status.done)
        else $error("unit done one cycle after start");
`endif

endmodule

FILE: sim/ddo_checker.sv
`timescale 1ns / 1ps

module ddo_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] right_distance,
    input  logic signed [31:0] left_distance,
    input  logic [23:0]        elapsed_us,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] turn_rate,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hd;
        logic [31:0] spd;
        logic [31:0] rate;
    } pose_word_t;

    pose_word_t  pose_q[$];
    logic [30:0] wheel_base;
    logic [31:0] last_r, last_l, px, py;
    logic [15:0] ph;

    localparam longint ATAN_TBL[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic rotate_bam(input logic [31:0] ang, output longint co, output longint si);
        bit     flip;
        longint x, y, z, xs, ys;
        flip = 0;
        x = 652032874;
        y = 0;
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000)
        begin
            ang = ang - 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < ddo_pkg::CORDIC_ITERS && i < 24; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end
            else
            begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endtask

    task automatic integrate_pose(input logic [31:0] r, input logic [31:0] l,
                                  input logic [23:0] dt);
        longint     dr, dl, dm, diff, tw, theta, chord, c, s, p, spd, rate, t;
        logic [31:0] full, half, dir;
        pose_word_t w;
        dr = longint'($signed(r - last_r));
        dl = longint'($signed(l - last_l));
        dm = (dr + dl) / 2;
        diff = dr - dl;
        tw = (wheel_base == 0) ? 1 : longint'(wheel_base);
        theta = 0;
        chord = dm;
        full = 0;
        half = 0;
        spd = 0;
        rate = 0;
        last_r = r;
        last_l = l;
        if (diff != 0)
            theta = clamp32(diff * 65536 / tw);
        if (theta != 0)
        begin
            p = theta * 683565276;
            full = 32'(floor_shr(p + 32768, 16));
            half = 32'(floor_shr(p + 65536, 17));
            rotate_bam(half, c, s);
            chord = dm * s / (theta * 8192);
        end
        dir = {ph, 16'h0} + half;
        rotate_bam(dir, c, s);
        px += 32'(floor_shr(chord * c + (64'sd1 << 29), 30));
        py += 32'(floor_shr(chord * s + (64'sd1 << 29), 30));
        t = longint'({ph, 16'h0}) + full + 32'h8000;
        ph = 16'(t >> 16);
        if (dt != 0)
        begin
            spd = clamp32(dm * 1000000 / longint'(dt));
            rate = clamp32(theta * 1000000 / longint'(dt));
        end
        w.x = px; w.y = py; w.hd = ph;
        w.spd = 32'(spd); w.rate = 32'(rate);
        pose_q.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pose_word_t w;
        if (!rst_n)
        begin
            wheel_base = ddo_pkg::TW_RESET;
            last_r = 0; last_l = 0; px = 0; py = 0; ph = 0;
        end
        else
        begin
            if (cfg_we)
                wheel_base = cfg_data;
            if (in_valid && in_ready)
                integrate_pose(right_distance, left_distance, elapsed_us);
            if (out_valid && out_ready)
            begin
                if (pose_q.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    w = pose_q.pop_front();
                    if (pos_x !== w.x) report_mismatch("pos_x", pos_x, w.x);
                    if (pos_y !== w.y) report_mismatch("pos_y", pos_y, w.y);
                    if (heading !== w.hd) report_mismatch("heading", 32'(heading), 32'(w.hd));
                    if (speed !== w.spd) report_mismatch("speed", speed, w.spd);
                    if (turn_rate !== w.rate)
                        report_mismatch("turn_rate", turn_rate, w.rate);
                end
            end
        end
        pending = pose_q.size();
    end

endmodule

FILE: sim/tb_diff_drive_odometry_update.sv
`timescale 1ns / 1ps

module tb_diff_drive_odometry_update;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] right_distance = 0;
    logic signed [31:0] left_distance = 0;
    logic [23:0]        elapsed_us = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] pos_x, pos_y, speed, turn_rate;
    logic signed [15:0] heading;
    logic               cfg_we = 0;
    logic [30:0]        cfg_data = 0;
    int                 fail_count, pending;
    longint             cycles = 0;
    logic [31:0]        odo_r = 0, odo_l = 0;
    bit                 sending_done = 0;

    localparam longint CYCLE_LIMIT = 6_000_000;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    diff_drive_odometry_update i_dut (.*);

    ddo_checker i_chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_diff_drive_odometry_update: errors");
            $finish;
        end
    end

    // random output stall per word
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // valid stays high into the next word when there is no gap
    task automatic send_word(input logic [31:0] r, input logic [31:0] l,
                             input logic [23:0] dt, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        right_distance <= r;
        left_distance <= l;
        elapsed_us <= dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // advance wheels by deltas
    task automatic step_wheels(input logic [31:0] dr, input logic [31:0] dl,
                               input logic [23:0] dt, input bit idle);
        odo_r += dr;
        odo_l += dl;
        send_word(odo_r, odo_l, dt, idle);
    endtask

    task automatic set_track(input logic [30:0] tw);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= tw;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    initial
    begin
        logic [30:0] tw_set[6];
        logic [31:0] d;
        bit          idle;
        tw_set = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd32768, 31'd200000};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // straight, extremes, zero time, huge turns
        step_wheels(32'd65536, 32'd65536, 24'd100000, 0);
        step_wheels(32'd1000, 32'd3000, 24'd0, 0);
        step_wheels(32'd70000, 32'd10000, 24'hFFFFFF, 1);
        step_wheels(32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 1);
        step_wheels(32'h8000_0000, 32'h7FFF_FFFF, 24'd1, 0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1, 0);
        send_word(32'h8000_0000, 32'h8000_0000, 24'd1, 0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 0);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 24'd1, 1);
        send_word(32'h0, 32'hFFFF_FFFF, 24'd0, 1);
        odo_r = 32'h0; odo_l = 32'hFFFF_FFFF;
        step_wheels(32'd1, 32'd0, 24'd1000, 0);
        step_wheels(32'd0, 32'd0, 24'd0, 0);
        step_wheels(-32'sd50000, 32'd50000, 24'd5000, 1);
        for (int k = 0; k < 8; k++)
            step_wheels(32'd52000, -32'sd52000, 24'd10000, 1);

        for (int ph_i = 0; ph_i < 6; ph_i++)
        begin
            set_track(tw_set[ph_i]);
            for (int n = 0; n < 240; n++)
            begin
                idle = $urandom_range(0, 4) != 0;
                d = rand_delta();
                if ($urandom_range(0, 9) == 0)
                    step_wheels(d, d, 24'($urandom), idle);
                else if ($urandom_range(0, 19) == 0)
                    send_word($urandom, $urandom, ($urandom_range(0, 3) == 0) ? 24'd0
                              : 24'($urandom), idle);
                else
                    step_wheels(d, rand_delta(), ($urandom_range(0, 7) == 0) ? 24'd0
                                : 24'($urandom_range(1, 200000)), idle);
            end
        end

        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_diff_drive_odometry_update: clean");
        else
            $display("tb_diff_drive_odometry_update: errors");
        $finish;
    end

endmodule
